// ----- rtl/ppr_pkg.sv -----
// Shared types and constants for the pinhole primary ray generator.
// No dependencies; every other file in rtl/ imports this package.
package ppr_pkg;

    localparam int REG_W    = 63;   // packed xyz register
    localparam int DATA_W   = 64;   // configuration data bus
    localparam int ADDR_W   = 5;    // registers at byte offsets 0, 8, 16, 24
    localparam int COMP_W   = 21;   // one signed vector component
    localparam int PIX_W    = 20;   // unsigned 12.8 pixel coordinate
    localparam int PIX_FRAC = 8;
    localparam int DIR_W    = 16;   // signed Q1.14 direction
    localparam int UNIT_SH  = 14;   // log2 of the unit length

    localparam int CE_W     = COMP_W + 1;           // corner minus eye
    localparam int PROD_W   = COMP_W + PIX_W + 1;   // component times coordinate
    localparam int D_W      = PROD_W + 2;           // displacement component
    localparam int MAG_W    = D_W - 1;              // its magnitude
    localparam int LEAD_W   = 6;                    // leading-one position
    localparam int NORM_TOP = 23;                   // normalized msb position
    localparam int NMAG_W   = NORM_TOP + 1;
    localparam int SQ_W     = 2 * NMAG_W;
    localparam int SUM_W    = SQ_W + 2;
    localparam int ROOT_W   = SUM_W / 2;
    localparam int REM_W    = ROOT_W + 2;
    localparam int NUM_W    = NMAG_W + UNIT_SH + 1;
    localparam int Q_W      = UNIT_SH + 1;

    typedef enum logic [1:0] {
        REG_EYE    = 2'd0,
        REG_CORNER = 2'd1,
        REG_ACROSS = 2'd2,
        REG_DOWN   = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_x;
        logic [PIX_W-1:0] pixel_y;
    } pix_t;

    typedef struct packed {
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
        logic signed [DIR_W-1:0] dir_z;
        logic                    degenerate;
    } ray_t;

    // Square-root pipeline payload: radicand, partial root and the sideband.
    typedef struct packed {
        logic [SUM_W-1:0]            s;
        logic [REM_W-1:0]            rem;
        logic [ROOT_W-1:0]           root;
        logic [2:0][NMAG_W-1:0]      mag;
        logic [2:0]                  neg;
        logic                        deg;
    } sq_t;

    // Divider pipeline payload: divisor, three partial remainders and quotients.
    typedef struct packed {
        logic [ROOT_W-1:0]           r;
        logic [2:0][NUM_W-1:0]       rem;
        logic [2:0][Q_W-1:0]         q;
        logic [2:0]                  neg;
        logic                        deg;
    } dv_t;

endpackage

// ----- rtl/ppr_isqrt.sv -----
// Pipelined integer square root, one result bit per stage.
// Depends on ppr_pkg (sq_t and widths).
module ppr_isqrt
    import ppr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic up_valid,
    output logic up_stall,
    input  sq_t  up_data,
    output logic dn_valid,
    input  logic dn_stall,
    output sq_t  dn_data
);

    function automatic sq_t sq_step(sq_t a, logic [1:0] bits);
        logic [REM_W+1:0] cur;
        logic [REM_W+1:0] trial;
        sq_t              b;
        b     = a;
        cur   = {a.rem, bits};
        trial = (REM_W+2)'({a.root, 2'b01});
        if (cur >= trial)
        begin
            b.rem  = REM_W'(cur - trial);
            b.root = {a.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            b.rem  = REM_W'(cur);
            b.root = {a.root[ROOT_W-2:0], 1'b0};
        end
        return b;
    endfunction

    sq_t               stg_reg  [ROOT_W];
    sq_t               stg_next [ROOT_W];
    logic [ROOT_W-1:0] vld_reg;
    logic [ROOT_W-1:0] load;

    genvar k;
    generate
        for (k = 0; k < ROOT_W; k++)
        begin : g_step
            sq_t  src;
            logic src_v;
            if (k == 0)
            begin : g_first
                assign src   = up_data;
                assign src_v = up_valid;
            end
            else
            begin : g_mid
                assign src   = stg_reg[k-1];
                assign src_v = vld_reg[k-1];
            end
            if (k == ROOT_W - 1)
            begin : g_last
                assign load[k] = !vld_reg[k] || !dn_stall;
            end
            else
            begin : g_chain
                assign load[k] = !vld_reg[k] || load[k+1];
            end

            // Pair of radicand bits for this step, most significant first.
            assign stg_next[k] = sq_step(src, src.s[2*(ROOT_W-1-k) +: 2]);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[k] <= 1'b0;
                else if (load[k])
                    vld_reg[k] <= src_v;
            end

            always_ff @(posedge clk)
            begin
                if (load[k])
                    stg_reg[k] <= stg_next[k];
            end
        end
    endgenerate

    assign up_stall = !load[0];
    assign dn_valid = vld_reg[ROOT_W-1];
    assign dn_data  = stg_reg[ROOT_W-1];

endmodule

// ----- rtl/ppr_divq.sv -----
// Pipelined rounding divider for the three direction lanes, with sign and output register.
// Depends on ppr_pkg (sq_t, dv_t, ray_t and widths).
module ppr_divq
    import ppr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic up_valid,
    output logic up_stall,
    input  sq_t  up_data,
    output logic dn_valid,
    input  logic dn_stall,
    output ray_t dn_data
);

    localparam int NSTG = Q_W + 1;

    function automatic dv_t dv_step(dv_t a, logic [NUM_W-1:0] dvs);
        dv_t b;
        b = a;
        for (int i = 0; i < 3; i++)
        begin
            if (a.rem[i] >= dvs)
            begin
                b.rem[i] = a.rem[i] - dvs;
                b.q[i]   = {a.q[i][Q_W-2:0], 1'b1};
            end
            else
            begin
                b.q[i]   = {a.q[i][Q_W-2:0], 1'b0};
            end
        end
        return b;
    endfunction

    dv_t             stg_reg  [NSTG];
    dv_t             stg_next [NSTG];
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] load;
    ray_t            out_reg;
    ray_t            out_next;
    logic            out_vld_reg;
    logic            out_load;

    // Numerator: magnitude scaled to the unit length plus half the divisor.
    always_comb
    begin
        stg_next[0].r   = up_data.root;
        stg_next[0].neg = up_data.neg;
        stg_next[0].deg = up_data.deg;
        for (int i = 0; i < 3; i++)
        begin
            stg_next[0].rem[i] = (NUM_W'(up_data.mag[i]) << UNIT_SH)
                               + NUM_W'(up_data.root >> 1);
            stg_next[0].q[i]   = '0;
        end
    end

    genvar k;
    generate
        for (k = 1; k < NSTG; k++)
        begin : g_step
            // Quotient bit Q_W-k, divisor shifted to that weight.
            assign stg_next[k] = dv_step(stg_reg[k-1],
                                         NUM_W'(stg_reg[k-1].r) << (Q_W - k));
        end
        for (k = 0; k < NSTG; k++)
        begin : g_reg
            logic src_v;
            if (k == 0)
            begin : g_first
                assign src_v = up_valid;
            end
            else
            begin : g_mid
                assign src_v = vld_reg[k-1];
            end
            if (k == NSTG - 1)
            begin : g_last
                assign load[k] = !vld_reg[k] || out_load;
            end
            else
            begin : g_chain
                assign load[k] = !vld_reg[k] || load[k+1];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[k] <= 1'b0;
                else if (load[k])
                    vld_reg[k] <= src_v;
            end

            always_ff @(posedge clk)
            begin
                if (load[k])
                    stg_reg[k] <= stg_next[k];
            end
        end
    endgenerate

    // Apply signs; a zero displacement forces a zero vector.
    always_comb
    begin
        logic [2:0][DIR_W-1:0] d;
        dv_t                   f;
        f = stg_reg[NSTG-1];
        for (int i = 0; i < 3; i++)
        begin
            if (f.deg)
                d[i] = '0;
            else if (f.neg[i])
                d[i] = -DIR_W'(f.q[i]);
            else
                d[i] = DIR_W'(f.q[i]);
        end
        out_next.dir_x      = d[0];
        out_next.dir_y      = d[1];
        out_next.dir_z      = d[2];
        out_next.degenerate = f.deg;
    end

    assign out_load = !out_vld_reg || !dn_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (out_load)
            out_vld_reg <= vld_reg[NSTG-1];
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_reg <= out_next;
    end

    assign up_stall = !load[0];
    assign dn_valid = out_vld_reg;
    assign dn_data  = out_reg;

endmodule

// ----- rtl/pinhole_primary_ray_gen.sv -----
// Top level of the pinhole primary ray generator: APB registers, front stages, sqrt, divide.
// Depends on ppr_pkg, ppr_isqrt and ppr_divq.
//
// Usage:
//   Program eye_position, plane_corner, step_across and step_down over the APB
//   port (64-bit data, register n at byte offset 8*n) while the block is idle.
//   Each input beat on in_valid/in_stall carries a pixel (x, y) in 12.8 fixed
//   point; each output beat on out_valid/out_stall carries the unit direction
//   in signed Q1.14 and the degenerate flag. The ray origin is eye_position.
// Timing:
//   One beat in and one beat out per cycle, sustained while out_stall is low. A beat
//   passes 7 front stages (multiply, sum, magnitude, leading-one search, normalize,
//   square, sum of squares), 25 square-root stages (one root bit each) and 16
//   divider stages (a numerator stage, then one quotient bit per stage for all
//   three lanes) plus the output register.
// Stall:
//   Every stage holds a valid bit; a stage advances when it is empty or its
//   successor advances, so bubbles close up while out_stall is high and the
//   input keeps taking beats until the whole pipeline is full.
// Reset:
//   Clears all valid bits and all four registers to zero.
module pinhole_primary_ray_gen
    import ppr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_stall,
    input  pix_t              in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output ray_t              out_data
);

    function automatic logic signed [COMP_W-1:0] comp_of(logic [REG_W-1:0] v, logic [1:0] idx);
        return v[COMP_W*idx +: COMP_W];
    endfunction

    // ---------------------------------------------------------------- registers
    logic [REG_W-1:0] eye_reg;
    logic [REG_W-1:0] corner_reg;
    logic [REG_W-1:0] across_reg;
    logic [REG_W-1:0] down_reg;
    cfg_reg_t         sel;

    assign sel    = cfg_reg_t'(paddr[ADDR_W-1:ADDR_W-2]);
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eye_reg    <= '0;
            corner_reg <= '0;
            across_reg <= '0;
            down_reg   <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            case (sel)
                REG_EYE:    eye_reg    <= pwdata[REG_W-1:0];
                REG_CORNER: corner_reg <= pwdata[REG_W-1:0];
                REG_ACROSS: across_reg <= pwdata[REG_W-1:0];
                REG_DOWN:   down_reg   <= pwdata[REG_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (sel)
            REG_EYE:    prdata = {1'b0, eye_reg};
            REG_CORNER: prdata = {1'b0, corner_reg};
            REG_ACROSS: prdata = {1'b0, across_reg};
            REG_DOWN:   prdata = {1'b0, down_reg};
            default:    prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- front stages
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic ld1, ld2, ld3, ld4, ld5, ld6, ld7;
    logic sq_stall;

    logic signed [PROD_W-1:0] pa_reg [3];
    logic signed [PROD_W-1:0] pa_next [3];
    logic signed [PROD_W-1:0] pd_reg [3];
    logic signed [PROD_W-1:0] pd_next [3];
    logic signed [CE_W-1:0]   ce_reg [3];
    logic signed [CE_W-1:0]   ce_next [3];
    logic signed [D_W-1:0]    d_reg [3];
    logic signed [D_W-1:0]    d_next [3];
    logic [MAG_W-1:0]         mag3_reg [3];
    logic [MAG_W-1:0]         mag3_next [3];
    logic [2:0]               neg3_reg, neg3_next;
    logic [MAG_W-1:0]         mag4_reg [3];
    logic [2:0]               neg4_reg;
    logic [LEAD_W-1:0]        lead4_reg, lead4_next;
    logic                     zero4_reg, zero4_next;
    logic [NMAG_W-1:0]        nmag5_reg [3];
    logic [NMAG_W-1:0]        nmag5_next [3];
    logic [2:0]               neg5_reg;
    logic                     zero5_reg;
    logic [NMAG_W-1:0]        nmag6_reg [3];
    logic [SQ_W-1:0]          sqr6_reg [3];
    logic [SQ_W-1:0]          sqr6_next [3];
    logic [2:0]               neg6_reg;
    logic                     zero6_reg;
    logic [NMAG_W-1:0]        nmag7_reg [3];
    logic [SUM_W-1:0]         s7_reg, s7_next;
    logic [2:0]               neg7_reg;
    logic                     zero7_reg;

    // Advance a stage when it is empty or the next one advances.
    assign ld7      = !v7_reg || !sq_stall;
    assign ld6      = !v6_reg || ld7;
    assign ld5      = !v5_reg || ld6;
    assign ld4      = !v4_reg || ld5;
    assign ld3      = !v3_reg || ld4;
    assign ld2      = !v2_reg || ld3;
    assign ld1      = !v1_reg || ld2;
    assign in_stall = !ld1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else
        begin
            if (ld1) v1_reg <= in_valid;
            if (ld2) v2_reg <= v1_reg;
            if (ld3) v3_reg <= v2_reg;
            if (ld4) v4_reg <= v3_reg;
            if (ld5) v5_reg <= v4_reg;
            if (ld6) v6_reg <= v5_reg;
            if (ld7) v7_reg <= v6_reg;
        end
    end

    always_comb
    begin
        logic [MAG_W-1:0] any;
        for (int i = 0; i < 3; i++)
        begin
            // Stage 1: plane steps times pixel coordinate, corner minus eye.
            pa_next[i] = PROD_W'(comp_of(across_reg, 2'(i)))
                       * PROD_W'(signed'({1'b0, in_data.pixel_x}));
            pd_next[i] = PROD_W'(comp_of(down_reg, 2'(i)))
                       * PROD_W'(signed'({1'b0, in_data.pixel_y}));
            ce_next[i] = CE_W'(comp_of(corner_reg, 2'(i)))
                       - CE_W'(comp_of(eye_reg, 2'(i)));
            // Stage 2: exact displacement with pixel fraction bits aligned.
            d_next[i]  = (D_W'(ce_reg[i]) <<< PIX_FRAC) + D_W'(pa_reg[i]) + D_W'(pd_reg[i]);
            // Stage 3: split sign and magnitude.
            neg3_next[i] = d_reg[i][D_W-1];
            mag3_next[i] = d_reg[i][D_W-1] ? MAG_W'(-d_reg[i]) : MAG_W'(d_reg[i]);
            // Stage 5: shift so the largest magnitude has its msb at NORM_TOP.
            if (lead4_reg >= LEAD_W'(NORM_TOP))
                nmag5_next[i] = NMAG_W'(mag4_reg[i] >> (lead4_reg - LEAD_W'(NORM_TOP)));
            else
                nmag5_next[i] = NMAG_W'(mag4_reg[i] << (LEAD_W'(NORM_TOP) - lead4_reg));
            // Stage 6: squares.
            sqr6_next[i] = SQ_W'(nmag5_reg[i]) * SQ_W'(nmag5_reg[i]);
        end
        // Stage 4: the msb of the OR is the msb of the largest magnitude.
        any        = mag3_reg[0] | mag3_reg[1] | mag3_reg[2];
        zero4_next = (any == '0);
        lead4_next = '0;
        for (int b = 0; b < MAG_W; b++)
        begin
            if (any[b])
                lead4_next = LEAD_W'(b);
        end
        // Stage 7: sum of squares.
        s7_next = SUM_W'(sqr6_reg[0]) + SUM_W'(sqr6_reg[1]) + SUM_W'(sqr6_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            pa_reg <= pa_next;
            pd_reg <= pd_next;
            ce_reg <= ce_next;
        end
        if (ld2)
            d_reg <= d_next;
        if (ld3)
        begin
            mag3_reg <= mag3_next;
            neg3_reg <= neg3_next;
        end
        if (ld4)
        begin
            mag4_reg  <= mag3_reg;
            neg4_reg  <= neg3_reg;
            lead4_reg <= lead4_next;
            zero4_reg <= zero4_next;
        end
        if (ld5)
        begin
            nmag5_reg <= nmag5_next;
            neg5_reg  <= neg4_reg;
            zero5_reg <= zero4_reg;
        end
        if (ld6)
        begin
            nmag6_reg <= nmag5_reg;
            sqr6_reg  <= sqr6_next;
            neg6_reg  <= neg5_reg;
            zero6_reg <= zero5_reg;
        end
        if (ld7)
        begin
            nmag7_reg <= nmag6_reg;
            s7_reg    <= s7_next;
            neg7_reg  <= neg6_reg;
            zero7_reg <= zero6_reg;
        end
    end

    // ---------------------------------------------------------------- sqrt and divide
    sq_t  sq_in;
    sq_t  sq_out;
    logic sq_valid;
    logic dv_stall;

    always_comb
    begin
        sq_in.s    = s7_reg;
        sq_in.rem  = '0;
        sq_in.root = '0;
        sq_in.neg  = neg7_reg;
        sq_in.deg  = zero7_reg;
        for (int i = 0; i < 3; i++)
            sq_in.mag[i] = nmag7_reg[i];
    end

    ppr_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (v7_reg),
        .up_stall (sq_stall),
        .up_data  (sq_in),
        .dn_valid (sq_valid),
        .dn_stall (dv_stall),
        .dn_data  (sq_out)
    );

    ppr_divq u_divq (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (sq_valid),
        .up_stall (dv_stall),
        .up_data  (sq_out),
        .dn_valid (out_valid),
        .dn_stall (out_stall),
        .dn_data  (out_data)
    );

    // ---------------------------------------------------------------- checks
    a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.degenerate |->
            out_data.dir_x == '0 && out_data.dir_y == '0 && out_data.dir_z == '0)
        else $error("degenerate result with nonzero direction");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            out_data.dir_x >= -16'sd16384 && out_data.dir_x <= 16'sd16384 &&
            out_data.dir_y >= -16'sd16384 && out_data.dir_y <= 16'sd16384 &&
            out_data.dir_z >= -16'sd16384 && out_data.dir_z <= 16'sd16384)
        else $error("direction component beyond unit length");

    a_empty_front_takes: assert property (@(posedge clk) disable iff (!rst_n)
        !v1_reg |-> !in_stall)
        else $error("input stalled with an empty first stage");

endmodule

// ----- tb/ray_dir_checker.sv -----
// Checker for the pinhole primary ray generator: watches the pixel and ray channels,
// computes the expected unit direction per pixel beat and compares. Depends on ppr_pkg.
module ray_dir_checker
    import ppr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  pix_t              in_data,
    input  logic              out_valid,
    input  logic              out_stall,
    input  ray_t              out_data,
    input  logic [REG_W-1:0]  eye,
    input  logic [REG_W-1:0]  corner,
    input  logic [REG_W-1:0]  across,
    input  logic [REG_W-1:0]  down,
    output int                fail_count,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    ray_t expected_rays[$];

    function automatic longint signed lane(logic [REG_W-1:0] r, int idx);
        logic signed [COMP_W-1:0] c;
        c = r[idx*COMP_W +: COMP_W];
        return longint'(c);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic ray_t predict_ray(pix_t p);
        longint signed d;
        longint unsigned mag[3];
        logic neg[3];
        longint unsigned m, s, r, q;
        ray_t ray;
        m = 0;
        for (int i = 0; i < 3; i++)
        begin
            d = (lane(corner, i) - lane(eye, i)) * 256
              + lane(across, i) * longint'(p.pixel_x)
              + lane(down, i) * longint'(p.pixel_y);
            neg[i] = d < 0;
            mag[i] = neg[i] ? longint'(-d) : longint'(d);
            if (mag[i] > m) m = mag[i];
        end
        ray = '0;
        if (m == 0)
        begin
            ray.degenerate = 1'b1;
            return ray;
        end
        while (m >= (64'd1 << 24))
        begin
            m >>= 1;
            for (int i = 0; i < 3; i++) mag[i] >>= 1;
        end
        while (m < (64'd1 << 23))
        begin
            m <<= 1;
            for (int i = 0; i < 3; i++) mag[i] <<= 1;
        end
        s = mag[0]*mag[0] + mag[1]*mag[1] + mag[2]*mag[2];
        r = int_sqrt(s);
        q = (mag[0] * 16384 + (r >> 1)) / r;
        ray.dir_x = neg[0] ? -q[15:0] : q[15:0];
        q = (mag[1] * 16384 + (r >> 1)) / r;
        ray.dir_y = neg[1] ? -q[15:0] : q[15:0];
        q = (mag[2] * 16384 + (r >> 1)) / r;
        ray.dir_z = neg[2] ? -q[15:0] : q[15:0];
        return ray;
    endfunction

    assign pending = expected_rays.size();

    always @(posedge clk or negedge rst_n)
    begin
        ray_t want;
        int   errs;
        errs = 0;
        if (!rst_n)
        begin
            fail_count <= 0;
            expected_rays.delete();
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_rays.push_back(predict_ray(in_data));
            if (out_valid && !out_stall)
            begin
                if (expected_rays.size() == 0)
                begin
                    $error("ray beat with nothing expected");
                    errs++;
                end
                else
                begin
                    want = expected_rays.pop_front();
                    if (out_data.dir_x !== want.dir_x)
                    begin
                        $error("dir_x exp %0d got %0d", want.dir_x, out_data.dir_x);
                        errs++;
                    end
                    if (out_data.dir_y !== want.dir_y)
                    begin
                        $error("dir_y exp %0d got %0d", want.dir_y, out_data.dir_y);
                        errs++;
                    end
                    if (out_data.dir_z !== want.dir_z)
                    begin
                        $error("dir_z exp %0d got %0d", want.dir_z, out_data.dir_z);
                        errs++;
                    end
                    if (out_data.degenerate !== want.degenerate)
                    begin
                        $error("degenerate exp %0b got %0b", want.degenerate,
                               out_data.degenerate);
                        errs++;
                    end
                end
            end
            if (errs != 0)
                fail_count <= fail_count + errs;
        end
    end
endmodule

// ----- tb/pinhole_primary_ray_gen_tb.sv -----
// Top of the pinhole primary ray generator testbench: clock, reset, APB setup,
// pixel stimulus and verdict. Depends on ppr_pkg, ray_dir_checker and the block.
module pinhole_primary_ray_gen_tb;
    import ppr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic              clk;
    logic              rst_n;
    logic              psel, penable, pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              in_valid, in_stall;
    pix_t              in_data;
    logic              out_valid, out_stall;
    ray_t              out_data;
    int                fail_count, pending;
    longint            cycles;
    logic [REG_W-1:0]  eye_q, corner_q, across_q, down_q;

    // Receiver behavior: idle_on enables random stalls, hold_cycles forces a long stall.
    bit                idle_on;
    int                hold_cycles;

    localparam longint CYCLE_LIMIT = 400000;

    pinhole_primary_ray_gen dut (.*);

    ray_dir_checker checker_i (
        .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
        .eye(eye_q), .corner(corner_q), .across(across_q), .down(down_q),
        .fail_count, .pending
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog: count cycles and give up well past the slowest correct run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver: random stalls at about 27 percent unless held off or quiet.
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall   <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_stall <= idle_on ? ($urandom_range(99) < 27) : 1'b0;
    end

    // APB write: setup cycle, then access cycle; pready is always high.
    task automatic write_reg(cfg_reg_t idx, logic [REG_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(8 * int'(idx));
        pwdata  <= {1'b0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_EYE:    eye_q    = value;
            REG_CORNER: corner_q = value;
            REG_ACROSS: across_q = value;
            default:    down_q   = value;
        endcase
    endtask

    // Send one pixel beat: optional random idle first, then hold until accepted.
    // Valid stays high after acceptance; the next beat or drain drops it.
    task automatic send_pixel(logic [PIX_W-1:0] x, logic [PIX_W-1:0] y);
        while (idle_on && $urandom_range(99) < 27)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        in_data.pixel_x <= x;
        in_data.pixel_y <= y;
        do @(posedge clk); while (in_stall);
    endtask

    // Drop valid, let the pipeline drain, then allow its latency to pass
    // before touching registers.
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function automatic logic [COMP_W-1:0] comp_pick();
        case ($urandom_range(5))
            0: return 21'h100000;
            1: return 21'h0FFFFF;
            2: return 21'h000000;
            3: return COMP_W'($urandom_range(255)) - 21'd128;
            default: return COMP_W'($urandom);
        endcase
    endfunction

    function automatic logic [REG_W-1:0] vec_pick();
        return {comp_pick(), comp_pick(), comp_pick()};
    endfunction

    function automatic logic [PIX_W-1:0] pix_pick();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return PIX_W'($urandom_range(255));
            default: return PIX_W'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [REG_W-1:0] big_pos, big_neg;
        cycles = 0;
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        in_valid = 1'b0; in_data = '0; out_stall = 1'b0;
        idle_on = 1'b0; hold_cycles = 0;
        eye_q = '0; corner_q = '0; across_q = '0; down_q = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Reset registers are all zero: every pixel is degenerate.
        send_pixel('0, '0);
        send_pixel('1, '1);
        drain();

        // Extremes: all components at the most positive and most negative value.
        big_pos = {3{21'h0FFFFF}};
        big_neg = {3{21'h100000}};
        write_reg(REG_EYE, big_neg);
        write_reg(REG_CORNER, big_pos);
        write_reg(REG_ACROSS, big_pos);
        write_reg(REG_DOWN, big_pos);
        send_pixel('0, '0);
        send_pixel('1, '1);
        send_pixel('1, '0);
        drain();
        write_reg(REG_EYE, big_pos);
        write_reg(REG_CORNER, big_neg);
        write_reg(REG_ACROSS, big_neg);
        write_reg(REG_DOWN, big_neg);
        send_pixel('0, '0);
        send_pixel('1, '1);
        send_pixel('0, '1);
        drain();

        // Small displacement, exercising up-normalization; eye equals corner
        // so pixel zero is degenerate, the rest single-axis or diagonal.
        write_reg(REG_EYE, {21'd5, 21'd5, 21'd5});
        write_reg(REG_CORNER, {21'd5, 21'd5, 21'd5});
        write_reg(REG_ACROSS, {21'd0, 21'd0, 21'd1});
        write_reg(REG_DOWN, {21'd0, 21'h1FFFFF, 21'd0});
        send_pixel('0, '0);
        send_pixel(20'd1, '0);
        send_pixel('0, 20'd1);
        send_pixel(20'd256, 20'd256);
        send_pixel(20'h80000, 20'h7FFFF);
        drain();

        // Random phases with fresh register settings; random idling on both sides.
        idle_on = 1'b1;
        for (int ph = 0; ph < 10; ph++)
        begin
            write_reg(REG_EYE, vec_pick());
            write_reg(REG_CORNER, vec_pick());
            write_reg(REG_ACROSS, vec_pick());
            write_reg(REG_DOWN, vec_pick());
            // Quiet stretch in one phase: no idling on either side.
            idle_on = (ph != 3);
            // Long receiver hold-off in one phase: the block fills and stalls input.
            if (ph == 6) hold_cycles = 200;
            for (int k = 0; k < 128; k++)
                send_pixel(pix_pick(), pix_pick());
            idle_on = 1'b1;
            drain();
        end

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
